// ----- design/mtwg_pkg.sv -----
`default_nettype none

package mtwg_pkg;

	localparam int STATE_DEPTH  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int POS_W        = $clog2(STATE_DEPTH);
	localparam int PADDR_W      = 3;

	localparam logic [POS_W-1:0] LAST_POS   = POS_W'(STATE_DEPTH - 1);
	localparam logic [POS_W-1:0] FAR_OFFSET = POS_W'(TWIST_OFFSET);
	localparam logic [POS_W-1:0] DEPTH_POS  = POS_W'(STATE_DEPTH);

	localparam logic [31:0] MATRIX_A      = 32'h9908_b0df;
	localparam logic [31:0] TEMPER_B      = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C      = 32'hefc6_0000;
	localparam logic [31:0] SEED_MULT     = 32'd6069;
	localparam logic [31:0] FALLBACK_SEED = 32'd4357;

	// register word index (paddr bit 2 upward)
	localparam logic REG_SEED_VALUE = 1'b0;

endpackage

`default_nettype wire

// ----- design/mt19937_word_generator_core.sv -----
`default_nettype none

// 32-bit MT19937 word generator. Each req transaction returns one tempered word on the
// rsp channel. The 624-word state lives in one synchronous memory with two read ports and
// one write port; the twist is done lazily, one word per request, so steady-state throughput
// is one word per clock while rsp_ready stays high (a new request is taken in the cycle the
// previous word leaves the output register). Word i is twisted from the held value of entry
// i, entry i+1 and entry (i+397) mod 624, with the last two read ahead by the registered
// read ports; the new word is written back in place, which matches the bulk in-place twist
// exactly. Seeding writes one entry per cycle (seed, then 6069 times the previous word)
// through one registered 32x13 multiply, followed by the ST_PRIME state, which prefetches
// the first operands. After reset the state is seeded with the fallback seed 4357 before
// the first request is taken. A request with restart set is stalled while the core starts
// the reload and reloads the state from seed_value through the same ST_SEED and ST_PRIME
// states, and is then answered with the first word of the new sequence. The seed_value
// register sits at byte address 0 of the APB port; writes complete in the access cycle and pready is always high.
module mt19937_word_generator_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// apb configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [mtwg_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                 pwdata,
	output logic      [31:0]                 prdata,
	output logic                             pready,
	// request channel
	input  wire logic                        req_valid,
	output logic                             req_ready,
	input  wire logic                        restart,
	// response channel
	output logic                             rsp_valid,
	input  wire logic                        rsp_ready,
	output logic      [31:0]                 random_word
);

	localparam int PW = mtwg_pkg::POS_W;

	typedef enum logic [1:0] {
		ST_SEED,
		ST_PRIME,
		ST_RUN
	} state_t;

	state_t state_q;

	// configuration
	logic [31:0] seed_q;

	// position of the next word to hand out and its current (pre-twist) value
	logic [PW-1:0] pos_q;
	logic [31:0]   cur_q;

	// seeding sweep
	logic [PW-1:0] cnt_q;
	logic [31:0]   val_q;

	// set when a restart reseed starts, so the waiting restart transaction is taken once it ends
	logic just_seeded_q;

	// output register
	logic        rsp_valid_q;
	logic [31:0] random_word_q;

	// state memory and its registered read data
	logic [31:0] state_mem [mtwg_pkg::STATE_DEPTH];
	logic [31:0] rd_nxt_q;
	logic [31:0] rd_far_q;

	logic          accept;
	logic          restart_req;
	logic          out_free;
	logic [PW-1:0] pos_inc;
	logic [PW-1:0] pos_nxt;
	logic [PW-1:0] addr_nxt;
	logic [PW-1:0] far_sum;
	logic [PW-1:0] addr_far;
	logic [31:0]   twist_y;
	logic [31:0]   twisted;
	logic          mem_we;
	logic [PW-1:0] mem_waddr;
	logic [31:0]   mem_wdata;
	logic          cfg_write;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & mtwg_pkg::TEMPER_B);
		y = y ^ ((y << 15) & mtwg_pkg::TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

	// apb: register written in the access phase
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign prdata    = (paddr[mtwg_pkg::PADDR_W-1] == mtwg_pkg::REG_SEED_VALUE) ? seed_q : 32'd0;

	// handshake
	assign out_free    = !rsp_valid_q || rsp_ready;
	assign restart_req = (state_q == ST_RUN) && req_valid && restart && !just_seeded_q;
	assign req_ready   = (state_q == ST_RUN) && out_free && (!restart || just_seeded_q);
	assign accept      = req_valid && req_ready;
	assign rsp_valid   = rsp_valid_q;
	assign random_word = random_word_q;

	// one twist step on the current position
	assign twist_y = {cur_q[31], rd_nxt_q[30:0]};
	assign twisted = rd_far_q ^ (twist_y >> 1) ^ (twist_y[0] ? mtwg_pkg::MATRIX_A : 32'd0);

	// read addresses for the position that holds after this edge
	assign pos_inc  = (pos_q == mtwg_pkg::LAST_POS) ? '0 : pos_q + PW'(1);
	assign pos_nxt  = accept ? pos_inc : pos_q;
	assign addr_nxt = (pos_nxt == mtwg_pkg::LAST_POS) ? '0 : pos_nxt + PW'(1);
	assign far_sum  = pos_nxt + mtwg_pkg::FAR_OFFSET;
	assign addr_far = (far_sum >= mtwg_pkg::DEPTH_POS) ? far_sum - mtwg_pkg::DEPTH_POS : far_sum;

	// write port: seeding sweep or twist write-back
	assign mem_we    = (state_q == ST_SEED) || accept;
	assign mem_waddr = (state_q == ST_SEED) ? cnt_q : pos_q;
	assign mem_wdata = (state_q == ST_SEED) ? val_q : twisted;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem[mem_waddr] <= mem_wdata;
		end
		rd_nxt_q <= state_mem[addr_nxt];
		rd_far_q <= state_mem[addr_far];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SEED;
			seed_q        <= mtwg_pkg::FALLBACK_SEED;
			pos_q         <= '0;
			cur_q         <= mtwg_pkg::FALLBACK_SEED;
			cnt_q         <= '0;
			val_q         <= mtwg_pkg::FALLBACK_SEED;
			just_seeded_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
			random_word_q <= '0;
		end else begin
			if (cfg_write && paddr[mtwg_pkg::PADDR_W-1] == mtwg_pkg::REG_SEED_VALUE) begin
				seed_q <= pwdata;
			end

			if (accept) begin
				rsp_valid_q   <= 1'b1;
				random_word_q <= temper(twisted);
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_SEED: begin
					// chain seed*6069^k, one entry per cycle
					val_q <= val_q * mtwg_pkg::SEED_MULT;
					if (cnt_q == mtwg_pkg::LAST_POS) begin
						cnt_q   <= '0;
						state_q <= ST_PRIME;
					end else begin
						cnt_q <= cnt_q + PW'(1);
					end
				end
				ST_PRIME: begin
					// operands for word 0 are being read this cycle
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (accept) begin
						pos_q         <= pos_inc;
						cur_q         <= rd_nxt_q;
						just_seeded_q <= 1'b0;
					end else if (restart_req) begin
						// reload from the configured seed; word 0 holds the seed itself
						state_q       <= ST_SEED;
						pos_q         <= '0;
						cnt_q         <= '0;
						val_q         <= seed_q;
						cur_q         <= seed_q;
						just_seeded_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_SEED;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
